/* rtl/glc_pkg.sv */
// Shared types, codes and helpers for the graph text line classifier.
`default_nettype none

package glc_pkg;

    localparam int MAX_LINE_LEN_DEF = 4095;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_DASH  = 8'h2D;

    localparam logic [15:0] RUN_MAX = 16'hFFFF;

    typedef enum logic [2:0] {
        KIND_REJECT = 3'd0,
        KIND_NODE   = 3'd1,
        KIND_EDGE   = 3'd2,
        KIND_ERROR  = 3'd3,
        KIND_EOL    = 3'd4,
        KIND_BLANK  = 3'd5
    } kind_t;

    typedef enum logic [1:0] {
        PH_START   = 2'd0,
        PH_CONTENT = 2'd1,
        PH_NEWLINE = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        N_EMPTY = 2'd0,
        N_WORD  = 2'd1,
        N_SPACE = 2'd2,
        N_DEAD  = 2'd3
    } node_t;

    typedef enum logic [3:0] {
        E_SP0    = 4'd0,
        E_SP1    = 4'd1,
        E_SP2    = 4'd2,
        E_SP3    = 4'd3,
        E_NEED_L = 4'd4,
        E_LWORD  = 4'd5,
        E_LSPACE = 4'd6,
        E_COLON  = 4'd7,
        E_NEED_R = 4'd8,
        E_RWORD  = 4'd9,
        E_RSPACE = 4'd10,
        E_DEAD   = 4'd11
    } edge_t;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       node_allowed;
        logic       edge_allowed;
        logic       error_allowed;
        logic       eol_allowed;
        logic       blank_allowed;
    } in_t;

    typedef struct packed {
        kind_t       token_kind;
        logic [15:0] token_length;
        logic [11:0] line_length;
    } out_t;

    // result of one word, handed from the core to the output stage
    typedef struct packed {
        logic valid;
        out_t word;
    } res_t;

    function automatic logic word_byte(input logic [7:0] b);
        word_byte = (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") ||
                    (b >= "0" && b <= "9") || b == CH_UNDER || b == CH_DASH;
    endfunction

endpackage

`default_nettype wire

/* rtl/glc_shape.sv */
// Next-state logic of the node and edge line shape trackers for one byte.
`default_nettype none

module glc_shape (
    input  wire glc_pkg::node_t n_in,
    input  wire glc_pkg::edge_t e_in,
    input  wire logic [7:0]     b,
    output glc_pkg::node_t      n_out,
    output glc_pkg::edge_t      e_out
);
    import glc_pkg::*;

    logic w;
    logic sp;

    assign w  = word_byte(b);
    assign sp = (b == CH_SP);

    always_comb begin
        case (n_in)
            N_EMPTY, N_SPACE: n_out = w ? N_WORD : N_DEAD;
            N_WORD:           n_out = w ? N_WORD : (sp ? N_SPACE : N_DEAD);
            default:          n_out = N_DEAD;
        endcase
    end

    always_comb begin
        case (e_in)
            E_SP0:              e_out = sp ? E_SP1 : E_DEAD;
            E_SP1:              e_out = sp ? E_SP2 : E_DEAD;
            E_SP2:              e_out = sp ? E_SP3 : E_DEAD;
            E_SP3:              e_out = sp ? E_NEED_L : E_DEAD;
            E_NEED_L, E_LSPACE: e_out = w ? E_LWORD : E_DEAD;
            E_LWORD: begin
                if (w)                  e_out = E_LWORD;
                else if (sp)            e_out = E_LSPACE;
                else if (b == CH_COLON) e_out = E_COLON;
                else                    e_out = E_DEAD;
            end
            E_COLON:            e_out = sp ? E_NEED_R : E_DEAD;
            E_NEED_R, E_RSPACE: e_out = w ? E_RWORD : E_DEAD;
            E_RWORD:            e_out = w ? E_RWORD : (sp ? E_RSPACE : E_DEAD);
            default:            e_out = E_DEAD;
        endcase
    end

endmodule

`default_nettype wire

/* rtl/glc_core.sv */
// Line state registers, line/newline-run sequencing and token classification.
`default_nettype none

module glc_core #(
    parameter int MAX_LINE_LEN = glc_pkg::MAX_LINE_LEN_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        adv,
    input  wire glc_pkg::in_t in_word,
    output glc_pkg::res_t    res
);
    import glc_pkg::*;

    localparam int CW = $clog2(MAX_LINE_LEN + 1);
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_LINE_LEN);

    phase_t        phase_reg, phase_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    node_t         node_reg, node_next;
    edge_t         edge_reg, edge_next;
    logic [15:0]   run_reg, run_next;

    logic [7:0]    b;
    logic          in_content;
    logic          is_end;
    node_t         n_base, n_fed, n_cls;
    edge_t         e_base, e_fed, e_cls;
    logic [CW-1:0] cnt_base, cnt_fed, cnt_cls;
    logic [15:0]   cnt_wide;
    logic [16:0]   blank_sum;
    logic [15:0]   blank_len;
    out_t          cls_word;
    out_t          eol_word;
    out_t          blank_word;

    assign b          = in_word.text_byte;
    assign in_content = (phase_reg == PH_CONTENT);
    assign is_end     = (b == CH_NL) || (b == CH_NUL);

    // a fresh line starts from empty shapes
    assign n_base   = in_content ? node_reg : N_EMPTY;
    assign e_base   = in_content ? edge_reg : E_SP0;
    assign cnt_base = in_content ? cnt_reg : '0;
    assign cnt_fed  = cnt_base + CW'(1);

    glc_shape u_shape (
        .n_in  (n_base),
        .e_in  (e_base),
        .b     (b),
        .n_out (n_fed),
        .e_out (e_fed)
    );

    // terminator classifies the stored line, limit classifies the fed one
    assign n_cls    = (in_content && is_end) ? node_reg : n_fed;
    assign e_cls    = (in_content && is_end) ? edge_reg : e_fed;
    assign cnt_cls  = (in_content && is_end) ? cnt_reg  : cnt_fed;
    assign cnt_wide = 16'(cnt_cls);

    always_comb begin
        cls_word = '0;
        if (in_word.node_allowed && n_cls == N_WORD) begin
            cls_word.token_kind  = KIND_NODE;
            cls_word.line_length = cnt_wide[11:0];
        end else if (in_word.edge_allowed && e_cls == E_RWORD) begin
            cls_word.token_kind  = KIND_EDGE;
            cls_word.line_length = cnt_wide[11:0];
        end else if (in_word.error_allowed) begin
            cls_word.token_kind   = KIND_ERROR;
            cls_word.token_length = cnt_wide;
            cls_word.line_length  = cnt_wide[11:0];
        end else begin
            cls_word.token_kind = KIND_REJECT;
        end
    end

    assign blank_sum = {1'b0, run_reg} + 17'(b != CH_NUL);
    assign blank_len = blank_sum[16] ? RUN_MAX : blank_sum[15:0];

    always_comb begin
        eol_word   = '0;
        blank_word = '0;
        eol_word.token_kind = KIND_REJECT;
        blank_word.token_kind = KIND_REJECT;
        if (in_word.eol_allowed) begin
            eol_word.token_kind   = KIND_EOL;
            eol_word.token_length = 16'd1;
        end
        if (in_word.blank_allowed) begin
            blank_word.token_kind   = KIND_BLANK;
            blank_word.token_length = blank_len;
        end
    end

    always_comb begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        node_next  = node_reg;
        edge_next  = edge_reg;
        run_next   = run_reg;
        res        = '0;
        case (phase_reg)
            PH_CONTENT: begin
                if (is_end) begin
                    res.valid  = 1'b1;
                    res.word   = cls_word;
                    phase_next = (b == CH_NL) ? PH_NEWLINE : PH_START;
                    run_next   = (b == CH_NL) ? 16'd1 : 16'd0;
                end else begin
                    cnt_next  = cnt_fed;
                    node_next = n_fed;
                    edge_next = e_fed;
                    if (cnt_fed >= CNT_MAX) begin
                        res.valid  = 1'b1;
                        res.word   = cls_word;
                        phase_next = PH_START;
                    end
                end
            end
            PH_NEWLINE: begin
                if (b == CH_NL) begin
                    if (run_reg != RUN_MAX) run_next = run_reg + 16'd1;
                end else if (run_reg <= 16'd1) begin
                    res.valid = 1'b1;
                    res.word  = eol_word;
                    run_next  = '0;
                    if (b == CH_NUL) begin
                        phase_next = PH_START;
                    end else begin
                        cnt_next   = cnt_fed;
                        node_next  = n_fed;
                        edge_next  = e_fed;
                        phase_next = PH_CONTENT;
                    end
                end else begin
                    res.valid  = 1'b1;
                    res.word   = blank_word;
                    run_next   = '0;
                    phase_next = PH_START;
                end
            end
            default: begin
                phase_next = PH_START;
                if (b == CH_NL) begin
                    phase_next = PH_NEWLINE;
                    run_next   = 16'd1;
                end else if (b != CH_NUL) begin
                    cnt_next   = cnt_fed;
                    node_next  = n_fed;
                    edge_next  = e_fed;
                    phase_next = PH_CONTENT;
                    if (cnt_fed >= CNT_MAX) begin
                        res.valid  = 1'b1;
                        res.word   = cls_word;
                        phase_next = PH_START;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_START;
            cnt_reg   <= '0;
            node_reg  <= N_EMPTY;
            edge_reg  <= E_SP0;
            run_reg   <= '0;
        end else if (adv) begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            node_reg  <= node_next;
            edge_reg  <= edge_next;
            run_reg   <= run_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/graph_text_line_classifier_top.sv */
// Top level of the graph text line classifier: handshake and result register.
//
//   channel | ports                    | word
//   --------+--------------------------+-------------------------------------
//   input   | s_valid s_ready s_data   | one text byte plus five allow bits
//   result  | m_valid m_ready m_data   | token kind, token length, line length
//
// While s_ready is high, one byte is taken per cycle. The byte is scanned
// and the line state is updated in the cycle it is accepted; a token, when
// the byte completes one, shows up on m_* in the next cycle from the result
// register. Reset (aresetn low at a clock edge) returns to line start and
// empties the result register; no clearing pass is needed.
// s_ready is high whenever the result register is empty or being drained,
// so a held result stalls the input only while m_ready stays low.
`default_nettype none

module graph_text_line_classifier_top #(
    parameter int MAX_LINE_LEN = glc_pkg::MAX_LINE_LEN_DEF
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire glc_pkg::in_t  s_data,
    output logic               m_valid,
    input  wire logic          m_ready,
    output glc_pkg::out_t      m_data
);
    import glc_pkg::*;

    logic accept;
    res_t res;
    logic m_valid_reg;
    out_t m_data_reg;

    // take a new byte whenever the result slot will be free at this edge
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    glc_core #(
        .MAX_LINE_LEN (MAX_LINE_LEN)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .adv     (accept),
        .in_word (s_data),
        .res     (res)
    );

    // result register: loads on accept, drops valid once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= res.valid;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && res.valid) begin
            m_data_reg <= res.word;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire
